// ===== rtl/iff_chunk_scanner_macros.svh =====
// ----------------------------------------------------------------------------
// iff chunk scanner assertion macros
// shared assertion forms for the scanner modules, clocked on clk,
// disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef IFF_CHUNK_SCANNER_MACROS_SVH
`define IFF_CHUNK_SCANNER_MACROS_SVH

// condition holds at every edge
`define ICS_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// antecedent at one edge implies consequent at the next
`define ICS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ics_pkg.sv =====
// ----------------------------------------------------------------------------
// ics_pkg
// types and constants shared by the iff chunk scanner modules
// ----------------------------------------------------------------------------
`default_nettype none

package ics_pkg;

	localparam logic [31:0] ID_FORM = 32'h464F524D;
	localparam logic [31:0] ID_LIST = 32'h4C495354;
	localparam logic [31:0] ID_CAT  = 32'h43415420;

	localparam int HDR_LEN  = 8;
	localparam int TYPE_LEN = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_STOP_TYPE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_ID    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT0      = 3'd3;

	localparam int QDEPTH = 2;

	typedef enum logic [2:0] {
		EV_OK     = 3'd0,
		EV_PROP   = 3'd1,
		EV_STOP   = 3'd2,
		EV_NOTIFF = 3'd3,
		EV_EOF    = 3'd4,
		EV_LIST   = 3'd5,
		EV_IGN    = 3'd6
	} ics_event_t;

	typedef enum logic [2:0] {
		PH_FILE  = 3'd0,
		PH_CHUNK = 3'd1,
		PH_DATA  = 3'd2,
		PH_PAD   = 3'd3,
		PH_PEND  = 3'd4,
		PH_DONE  = 3'd5
	} ics_phase_t;

	typedef struct packed {
		logic       action;
		logic [7:0] file_byte;
	} ics_in_word_t;

	typedef struct packed {
		ics_event_t  event_res;
		logic [7:0]  prop_byte;
		logic [1:0]  prop_slot;
		logic        prop_last;
		logic        chunk_valid;
		logic [31:0] chunk_id;
		logic [31:0] chunk_size;
	} ics_out_word_t;

	typedef struct packed {
		logic       is_end;
		logic [7:0] data;
	} ics_entry_t;

	typedef struct packed {
		logic       valid;
		ics_entry_t entry;
	} ics_head_t;

endpackage

`default_nettype wire

// ===== rtl/ics_front.sv =====
// ----------------------------------------------------------------------------
// ics_front
// accepts input words, sorts them into byte or end-of-stream entries and
// holds them in a short queue for the parser
// ----------------------------------------------------------------------------
`default_nettype none

module ics_front
	import ics_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	input  wire          in_valid,
	output logic         in_ready,
	input  ics_in_word_t in_word,
	output ics_head_t    head,
	input  wire          pop
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	ics_entry_t             entry_q [QDEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   push;
	logic                   do_pop;
	ics_entry_t             new_entry;

	assign in_ready = (count_q != CNT_W'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign do_pop   = pop && (count_q != '0);

	always_comb begin
		new_entry.is_end = in_word.action;
		new_entry.data   = in_word.action ? 8'd0 : in_word.file_byte;
	end

	assign head.valid = (count_q != '0);
	assign head.entry = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`include "iff_chunk_scanner_macros.svh"

	`ICS_ASSERT(a_count_bound, count_q <= CNT_W'(QDEPTH), "queue count above depth")
	`ICS_ASSERT_NEXT(a_full_holds, (count_q == CNT_W'(QDEPTH)) && !pop, count_q == CNT_W'(QDEPTH), "full queue lost an entry")
	`ICS_ASSERT_NEXT(a_empty_holds, (count_q == '0) && !in_valid, count_q == '0, "empty queue gained an entry")

endmodule

`default_nettype wire

// ===== rtl/ics_back.sv =====
// ----------------------------------------------------------------------------
// ics_back
// iff header and chunk parser: takes queue entries one per cycle while the
// output register is empty or out_ready is high, keeps the configuration
// registers and drives the registered result word
`default_nettype none

module ics_back
	import ics_pkg::*;
#(
	parameter int PROP_SLOTS = 4
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  ics_head_t             head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire                   out_ready,
	output ics_out_word_t         out_word,
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data
);

	logic [31:0]      stop_type_q;
	logic [31:0]      stop_id_q;
	logic [2:0]       prop_count_q;
	logic [63:0]      slot_q [PROP_SLOTS];

	ics_phase_t       phase_q, phase_d;
	logic [3:0]       header_pos_q, header_pos_d;
	logic [31:0]      header_word_q, header_word_d;
	logic [31:0]      form_kind_q, form_kind_d;
	logic [31:0]      current_id_q, current_id_d;
	logic [31:0]      current_size_q, current_size_d;
	logic [31:0]      bytes_left_q, bytes_left_d;
	logic [1:0]       hit_slot_q, hit_slot_d;
	logic             hit_prop_q, hit_prop_d;
	logic             hit_stop_q, hit_stop_d;
	logic             chunk_held_q, chunk_held_d;

	logic             out_valid_q;
	ics_out_word_t    out_q;
	ics_out_word_t    res;
	logic             found;
	logic [1:0]       found_slot;

	assign pop       = head.valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_type_q  <= '0;
			stop_id_q    <= '0;
			prop_count_q <= '0;
			for (int i = 0; i < PROP_SLOTS; i++) begin
				slot_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_STOP_TYPE) begin
				stop_type_q <= cfg_data[31:0];
			end
			if (cfg_index == REG_STOP_ID) begin
				stop_id_q <= cfg_data[31:0];
			end
			if (cfg_index == REG_PROP_COUNT) begin
				prop_count_q <= cfg_data[2:0];
			end
			for (int i = 0; i < PROP_SLOTS; i++) begin
				if (cfg_index == REG_SLOT0 + CFG_IDX_W'(i)) begin
					slot_q[i] <= cfg_data;
				end
			end
		end
	end

	// first slot in use whose form type and id match
	always_comb begin
		found      = 1'b0;
		found_slot = 2'd0;
		for (int i = 0; i < PROP_SLOTS; i++) begin
			if (!found && (3'(i) < prop_count_q) &&
			    (slot_q[i][63:32] == form_kind_q) &&
			    (slot_q[i][31:0] == current_id_q)) begin
				found      = 1'b1;
				found_slot = 2'(i);
			end
		end
	end

	always_comb begin
		phase_d        = phase_q;
		header_pos_d   = header_pos_q;
		header_word_d  = header_word_q;
		form_kind_d    = form_kind_q;
		current_id_d   = current_id_q;
		current_size_d = current_size_q;
		bytes_left_d   = bytes_left_q;
		hit_slot_d     = hit_slot_q;
		hit_prop_d     = hit_prop_q;
		hit_stop_d     = hit_stop_q;
		chunk_held_d   = chunk_held_q;
		res            = '0;
		res.event_res  = EV_OK;

		if (phase_q == PH_DONE) begin
			res.event_res = EV_IGN;
		end else if (phase_q == PH_PEND) begin
			res.event_res = EV_STOP;
			phase_d       = PH_DONE;
		end else if (head.entry.is_end) begin
			res.event_res = EV_EOF;
			phase_d       = PH_DONE;
			chunk_held_d  = 1'b0;
		end else begin
			unique case (phase_q)
				PH_FILE: begin
					header_word_d = {header_word_q[23:0], head.entry.data};
					if (header_pos_q == 4'd3) begin
						current_id_d = header_word_d;
					end else if (header_pos_q == 4'(HDR_LEN - 1)) begin
						if (current_id_q == ID_LIST || current_id_q == ID_CAT) begin
							res.event_res = EV_LIST;
							phase_d       = PH_DONE;
							chunk_held_d  = 1'b0;
						end else if (current_id_q != ID_FORM) begin
							res.event_res = EV_NOTIFF;
							phase_d       = PH_DONE;
							chunk_held_d  = 1'b0;
						end
						current_id_d = '0;
					end else if (header_pos_q == 4'(HDR_LEN + TYPE_LEN - 1)) begin
						form_kind_d = header_word_d;
						phase_d     = PH_CHUNK;
					end
					header_pos_d = (phase_d == PH_CHUNK) ? 4'd0 : header_pos_q + 4'd1;
				end
				PH_CHUNK: begin
					if (header_pos_q == 4'd0) begin
						chunk_held_d = 1'b0;
					end
					header_word_d = {header_word_q[23:0], head.entry.data};
					if (header_pos_q == 4'd3) begin
						current_id_d = header_word_d;
					end
					if (header_pos_q == 4'(HDR_LEN - 1)) begin
						current_size_d = header_word_d;
						chunk_held_d   = 1'b1;
						hit_prop_d     = found;
						hit_slot_d     = found_slot;
						hit_stop_d     = (stop_type_q == form_kind_q) &&
						                 (stop_id_q == current_id_q);
						bytes_left_d   = header_word_d;
						header_pos_d   = 4'd0;
						if (hit_stop_d && (!found || header_word_d == '0)) begin
							res.event_res = EV_STOP;
							phase_d       = PH_DONE;
						end else if (header_word_d == '0) begin
							phase_d = PH_CHUNK;
						end else begin
							phase_d = PH_DATA;
						end
					end else begin
						header_pos_d = header_pos_q + 4'd1;
					end
				end
				PH_DATA: begin
					if (hit_prop_q) begin
						res.event_res = EV_PROP;
						res.prop_byte = head.entry.data;
						res.prop_slot = hit_slot_q;
						res.prop_last = (bytes_left_q == 32'd1);
					end
					bytes_left_d = bytes_left_q - 32'd1;
					if (bytes_left_q == 32'd1) begin
						if (hit_stop_q) begin
							phase_d = PH_PEND;
						end else if (current_size_q[0]) begin
							phase_d = PH_PAD;
						end else begin
							phase_d = PH_CHUNK;
						end
					end
				end
				PH_PAD: begin
					phase_d = PH_CHUNK;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end

		res.chunk_valid = chunk_held_d;
		res.chunk_id    = chunk_held_d ? current_id_d : 32'd0;
		res.chunk_size  = chunk_held_d ? current_size_d : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_FILE;
			header_pos_q   <= '0;
			header_word_q  <= '0;
			form_kind_q    <= '0;
			current_id_q   <= '0;
			current_size_q <= '0;
			bytes_left_q   <= '0;
			hit_slot_q     <= '0;
			hit_prop_q     <= 1'b0;
			hit_stop_q     <= 1'b0;
			chunk_held_q   <= 1'b0;
		end else if (pop) begin
			phase_q        <= phase_d;
			header_pos_q   <= header_pos_d;
			header_word_q  <= header_word_d;
			form_kind_q    <= form_kind_d;
			current_id_q   <= current_id_d;
			current_size_q <= current_size_d;
			bytes_left_q   <= bytes_left_d;
			hit_slot_q     <= hit_slot_d;
			hit_prop_q     <= hit_prop_d;
			hit_stop_q     <= hit_stop_d;
			chunk_held_q   <= chunk_held_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

`include "iff_chunk_scanner_macros.svh"

	`ICS_ASSERT_NEXT(a_done_sticks, phase_q == PH_DONE, phase_q == PH_DONE, "parser left finished phase")
	`ICS_ASSERT(a_data_left, (phase_q != PH_DATA) || (bytes_left_q != '0), "data phase with no bytes left")
	`ICS_ASSERT(a_prop_in_chunk, !(out_valid_q && out_q.event_res == EV_PROP) || out_q.chunk_valid, "property byte outside a chunk")

endmodule

`default_nettype wire

// ===== rtl/iff_chunk_scanner.sv =====
// ----------------------------------------------------------------------------
// iff_chunk_scanner
// walks an iff file byte by byte and emits the data of selected chunks
// ----------------------------------------------------------------------------
// in_word carries one file byte, or an end-of-stream mark when action is set;
// every accepted word yields exactly one out_word with an event code, the
// property byte with its slot and last mark, and the current chunk header.
// configuration is written through cfg_we/cfg_index/cfg_data while idle:
// stop type and id, the number of property slots in use and the slots.
// an accepted word waits in the queue, is parsed once it is at the head and
// the output register is free, and its result is then held in that register.
// throughput is one word per cycle while out_ready keeps the output register
// free; the parser updates its header and byte counters once per word.
// a two-entry queue separates the input from the parser; when out_ready is
// low the output register holds, the queue fills and in_ready drops once it
// holds two words.
// reset empties the queue, drops out_valid, clears the configuration and puts
// the parser back at the start of the file header.
// after a stop, an error, a list or cat header or end of stream every
// further word yields the ignored code until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module iff_chunk_scanner
	import ics_pkg::*;
#(
	parameter int PROP_SLOTS = 4
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  ics_in_word_t          in_word,
	output logic                  out_valid,
	input  wire                   out_ready,
	output ics_out_word_t         out_word,
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data
);

	ics_head_t head;
	logic      pop;

	ics_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.head     (head),
		.pop      (pop)
	);

	ics_back #(
		.PROP_SLOTS (PROP_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire
